// ----- sv/pctf_pkg.sv -----
package pctf_pkg;

  // Geometry of the canvas store
  localparam int SIDE_BITS   = 6;
  localparam int MAX_SIDE    = 1 << SIDE_BITS;
  localparam int DIM_BITS    = SIDE_BITS + 1;
  localparam int ADDR_BITS   = 2 * SIDE_BITS;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int SP_BITS     = ADDR_BITS + 1;
  localparam int PIX_BITS    = 8;

  localparam logic [PIX_BITS-1:0] RESET_COLOUR = 8'hC4;
  localparam logic [PIX_BITS-1:0] TRANSPARENT  = 8'h00;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    OP_PENCIL = 3'd0,
    OP_FILL   = 3'd1,
    OP_PICK   = 3'd2,
    OP_ERASE  = 3'd3,
    OP_SETCOL = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_SKIPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_POP,
    S_LOAD,
    S_NRD,
    S_NCHK,
    S_FIN
  } state_t;

  // Input word fields, lowest bits last
  typedef struct packed {
    logic [PIX_BITS-1:0]  colour;
    logic [SIDE_BITS-1:0] y;
    logic [SIDE_BITS-1:0] x;
    logic [2:0]           op;
  } item_t;

  // Result word fields, lowest bits last
  typedef struct packed {
    logic [1:0]          status;
    logic [PIX_BITS-1:0] colour;
    logic [PIX_BITS-1:0] pix;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [PIX_BITS-1:0]  wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } canvas_req_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [ADDR_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } stack_req_t;

endpackage

// ----- sv/pixel_canvas_tool_with_flood_fill_unit.sv -----
// Channel   Dir  Fields (low bit first)                              Width
// s_*       in   opcode[2:0] pos_x[8:3] pos_y[14:9] colour_value[22:15] 24
// m_*       out  pixel_value[7:0] current_colour_out[15:8] status[17:16] 24
// cfg_*     in   index 0 canvas_width, 1 canvas_height                   7
//
// Pencil, erase, pick, set colour and read accept a word with the canvas read,
// then modify/write back and load the output register, waiting while it is full.
// Fill goes on from the seed: it pops each pixel (stack read, coordinate load),
// reads and checks each in-range neighbor one at a time over the single canvas
// read port of the sequencer, and loads the output register once the stack is empty.
// After reset a clearing pass zeroes all 4096 canvas words; s_tready is low.
// A stalled m_* word holds; a new word is accepted meanwhile, its result waits.
module pixel_canvas_tool_with_flood_fill_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,  // opcode, pos_x, pos_y, colour_value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,  // pixel_value, current_colour_out, status
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pctf_pkg::DIM_BITS-1:0] cfg_data
);

  logic [pctf_pkg::DIM_BITS-1:0] canvas_width, canvas_height;
  logic [pctf_pkg::DIM_BITS-1:0] width_eff, height_eff;

  pctf_pkg::canvas_req_t          canvas;
  pctf_pkg::stack_req_t           stack;
  logic [pctf_pkg::PIX_BITS-1:0]  canvas_rdata;
  logic [pctf_pkg::ADDR_BITS-1:0] stack_rdata;
  pctf_pkg::result_t              res;
  logic                           res_load;
  logic                           out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= pctf_pkg::DIM_BITS'(pctf_pkg::MAX_SIDE);
      canvas_height <= pctf_pkg::DIM_BITS'(pctf_pkg::MAX_SIDE);
    end else if (cfg_we) begin
      if (cfg_index == pctf_pkg::CFG_WIDTH) begin
        canvas_width <= cfg_data;
      end else begin
        canvas_height <= cfg_data;
      end
    end
  end

  // dimensions above the store side act as the full side
  assign width_eff  = (canvas_width > pctf_pkg::DIM_BITS'(pctf_pkg::MAX_SIDE)) ?
                      pctf_pkg::DIM_BITS'(pctf_pkg::MAX_SIDE) : canvas_width;
  assign height_eff = (canvas_height > pctf_pkg::DIM_BITS'(pctf_pkg::MAX_SIDE)) ?
                      pctf_pkg::DIM_BITS'(pctf_pkg::MAX_SIDE) : canvas_height;

  pctf_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .width        (width_eff),
    .height       (height_eff),
    .in_valid     (s_tvalid),
    .item         (pctf_pkg::item_t'(s_tdata[$bits(pctf_pkg::item_t)-1:0])),
    .in_ready     (s_tready),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .canvas       (canvas),
    .canvas_rdata (canvas_rdata),
    .stack        (stack),
    .stack_rdata  (stack_rdata)
  );

  pctf_ram #(
    .WIDTH (pctf_pkg::PIX_BITS),
    .DEPTH (pctf_pkg::STORE_DEPTH)
  ) u_canvas_ram (
    .clk   (clk),
    .we    (canvas.we),
    .waddr (canvas.waddr),
    .wdata (canvas.wdata),
    .re    (canvas.re),
    .raddr (canvas.raddr),
    .rdata (canvas_rdata)
  );

  pctf_ram #(
    .WIDTH (pctf_pkg::ADDR_BITS),
    .DEPTH (pctf_pkg::STORE_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack.we),
    .waddr (stack.waddr),
    .wdata (stack.wdata),
    .re    (stack.re),
    .raddr (stack.raddr),
    .rdata (stack_rdata)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {(24 - $bits(pctf_pkg::result_t))'(0), res};
    end
  end

  // result only loaded into a free output register
  assert property (@(posedge clk) disable iff (rst) res_load |-> out_free)
    else $error("result loaded over a waiting word");

  // one word in flight: ready drops after an accept
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while busy");

  // out-of-canvas results report a transparent pixel
  assert property (@(posedge clk) disable iff (rst)
    (res_load && res.status == pctf_pkg::ST_OUTSIDE) |-> (res.pix == pctf_pkg::TRANSPARENT))
    else $error("outside status with nonzero pixel");

  // no canvas read is issued in a cycle that loads a result
  assert property (@(posedge clk) disable iff (rst) res_load |-> !canvas.re)
    else $error("result loaded while a canvas read is pending");

endmodule

// ----- sv/pctf_ram.sv -----
// Simple dual-port RAM, one write and one registered read port
module pctf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pctf_engine.sv -----
// Tool sequencer: clearing pass, single-pixel read-modify-write, stack-based fill
module pctf_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [pctf_pkg::DIM_BITS-1:0]   width,
  input  logic [pctf_pkg::DIM_BITS-1:0]   height,
  input  logic                            in_valid,
  input  pctf_pkg::item_t                 item,
  output logic                            in_ready,
  input  logic                            out_free,
  output logic                            res_load,
  output pctf_pkg::result_t               res,
  output pctf_pkg::canvas_req_t           canvas,
  input  logic [pctf_pkg::PIX_BITS-1:0]   canvas_rdata,
  output pctf_pkg::stack_req_t            stack,
  input  logic [pctf_pkg::ADDR_BITS-1:0]  stack_rdata
);

  pctf_pkg::state_t state, state_next;

  logic [pctf_pkg::ADDR_BITS-1:0] clr_cnt;
  logic [pctf_pkg::PIX_BITS-1:0]  cur, cur_next;
  logic [pctf_pkg::SP_BITS-1:0]   sp, sp_next;
  logic [pctf_pkg::SP_BITS-1:0]   sp_dec;

  // latched item
  logic [2:0]                     op;
  logic [pctf_pkg::SIDE_BITS-1:0] px, py;
  logic [pctf_pkg::PIX_BITS-1:0]  cval;

  // fill walk
  logic [pctf_pkg::PIX_BITS-1:0]  from, from_next;
  logic [pctf_pkg::SIDE_BITS-1:0] cx, cy, nx, ny, nx_next, ny_next;
  logic [1:0]                     nb, nb_next;
  logic [pctf_pkg::SIDE_BITS-1:0] nbx, nby;
  logic                           nb_ok;

  logic [pctf_pkg::PIX_BITS-1:0]  res_pix, res_pix_next;
  logic [1:0]                     res_status, res_status_next;
  logic                           in_range;

  assign in_range = ({1'b0, px} < width) && ({1'b0, py} < height);
  assign sp_dec   = sp - pctf_pkg::SP_BITS'(1);

  // neighbor of the popped pixel, in range check
  always_comb begin
    nbx   = cx;
    nby   = cy;
    nb_ok = 1'b0;
    case (nb)
      2'd0: begin
        nbx   = cx + pctf_pkg::SIDE_BITS'(1);
        nb_ok = ({1'b0, cx} + pctf_pkg::DIM_BITS'(1)) < width;
      end
      2'd1: begin
        nbx   = cx - pctf_pkg::SIDE_BITS'(1);
        nb_ok = (cx != '0);
      end
      2'd2: begin
        nby   = cy + pctf_pkg::SIDE_BITS'(1);
        nb_ok = ({1'b0, cy} + pctf_pkg::DIM_BITS'(1)) < height;
      end
      default: begin
        nby   = cy - pctf_pkg::SIDE_BITS'(1);
        nb_ok = (cy != '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pctf_pkg::S_CLEAR;
      clr_cnt <= '0;
      cur     <= pctf_pkg::RESET_COLOUR;
      sp      <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      sp    <= sp_next;
      if (state == pctf_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + pctf_pkg::ADDR_BITS'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op   <= item.op;
      px   <= item.x;
      py   <= item.y;
      cval <= item.colour;
    end
    if (state == pctf_pkg::S_LOAD) begin
      cx <= stack_rdata[pctf_pkg::SIDE_BITS-1:0];
      cy <= stack_rdata[pctf_pkg::ADDR_BITS-1:pctf_pkg::SIDE_BITS];
    end
    from       <= from_next;
    nx         <= nx_next;
    ny         <= ny_next;
    nb         <= nb_next;
    res_pix    <= res_pix_next;
    res_status <= res_status_next;
  end

  // next state and memory requests
  always_comb begin
    state_next      = state;
    cur_next        = cur;
    sp_next         = sp;
    from_next       = from;
    nx_next         = nx;
    ny_next         = ny;
    nb_next         = nb;
    res_pix_next    = res_pix;
    res_status_next = res_status;
    canvas          = '0;
    stack           = '0;
    in_ready        = 1'b0;
    res_load        = 1'b0;
    res.pix         = res_pix;
    res.status      = res_status;

    unique case (state)
      pctf_pkg::S_CLEAR: begin
        canvas.we    = 1'b1;
        canvas.waddr = clr_cnt;
        canvas.wdata = pctf_pkg::TRANSPARENT;
        if (clr_cnt == '1) begin
          state_next = pctf_pkg::S_IDLE;
        end
      end

      pctf_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        canvas.re    = in_valid;
        canvas.raddr = {item.y, item.x};
        if (in_valid) begin
          state_next = pctf_pkg::S_EXEC;
        end
      end

      pctf_pkg::S_EXEC: begin
        if (op == pctf_pkg::OP_SETCOL) begin
          cur_next = cval;
        end
        res_status_next = pctf_pkg::ST_APPLIED;
        res_pix_next    = canvas_rdata;
        state_next      = pctf_pkg::S_FIN;
        canvas.waddr    = {py, px};
        if (!in_range) begin
          res_status_next = pctf_pkg::ST_OUTSIDE;
          res_pix_next    = pctf_pkg::TRANSPARENT;
        end else begin
          case (op)
            pctf_pkg::OP_PENCIL: begin
              canvas.we    = 1'b1;
              canvas.wdata = cur;
              res_pix_next = cur;
            end
            pctf_pkg::OP_ERASE: begin
              canvas.we    = 1'b1;
              canvas.wdata = pctf_pkg::TRANSPARENT;
              res_pix_next = pctf_pkg::TRANSPARENT;
            end
            pctf_pkg::OP_PICK: begin
              cur_next = canvas_rdata;
            end
            pctf_pkg::OP_FILL: begin
              if (canvas_rdata == cur) begin
                res_status_next = pctf_pkg::ST_SKIPPED;
              end else begin
                // recolor the seed and push it
                from_next    = canvas_rdata;
                canvas.we    = 1'b1;
                canvas.wdata = cur;
                stack.we     = 1'b1;
                stack.waddr  = '0;
                stack.wdata  = {py, px};
                sp_next      = pctf_pkg::SP_BITS'(1);
                res_pix_next = cur;
                state_next   = pctf_pkg::S_POP;
              end
            end
            default: ;
          endcase
        end
        res.pix    = res_pix_next;
        res.status = res_status_next;
        if (state_next == pctf_pkg::S_FIN && out_free) begin
          res_load   = 1'b1;
          state_next = pctf_pkg::S_IDLE;
        end
      end

      pctf_pkg::S_POP: begin
        if (sp == '0) begin
          state_next = pctf_pkg::S_FIN;
        end else begin
          stack.re    = 1'b1;
          stack.raddr = sp_dec[pctf_pkg::ADDR_BITS-1:0];
          sp_next     = sp_dec;
          state_next  = pctf_pkg::S_LOAD;
        end
      end

      pctf_pkg::S_LOAD: begin
        nb_next    = 2'd0;
        state_next = pctf_pkg::S_NRD;
      end

      pctf_pkg::S_NRD: begin
        if (nb_ok) begin
          canvas.re    = 1'b1;
          canvas.raddr = {nby, nbx};
          nx_next      = nbx;
          ny_next      = nby;
          state_next   = pctf_pkg::S_NCHK;
        end else if (nb == 2'd3) begin
          state_next = pctf_pkg::S_POP;
        end else begin
          nb_next = nb + 2'd1;
        end
      end

      pctf_pkg::S_NCHK: begin
        // matching neighbor: recolor and push
        if (canvas_rdata == from) begin
          canvas.we    = 1'b1;
          canvas.waddr = {ny, nx};
          canvas.wdata = cur;
          stack.we     = 1'b1;
          stack.waddr  = sp[pctf_pkg::ADDR_BITS-1:0];
          stack.wdata  = {ny, nx};
          sp_next      = sp + pctf_pkg::SP_BITS'(1);
        end
        if (nb == 2'd3) begin
          state_next = pctf_pkg::S_POP;
        end else begin
          nb_next    = nb + 2'd1;
          state_next = pctf_pkg::S_NRD;
        end
      end

      pctf_pkg::S_FIN: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = pctf_pkg::S_IDLE;
        end
      end

      default: state_next = pctf_pkg::S_IDLE;
    endcase

    res.colour = cur_next;
  end

endmodule

// ----- sim/tb_pixel_canvas_tool_with_flood_fill_unit.sv -----
`timescale 1ns / 100ps

module tb_pixel_canvas_tool_with_flood_fill_unit;

  // Opcodes past read pixel behave as read pixel
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Canvas settings per phase, phase 0 in the lowest bits
  localparam int PHASES = 10;
  localparam logic [7*PHASES-1:0] PHASE_W =
    {7'd7, 7'd64, 7'd2, 7'd8, 7'd3, 7'd5, 7'd64, 7'd1, 7'd127, 7'd0};
  localparam logic [7*PHASES-1:0] PHASE_H =
    {7'd6, 7'd3, 7'd2, 7'd8, 7'd64, 7'd4, 7'd1, 7'd64, 7'd127, 7'd5};
  localparam logic [8*PHASES-1:0] PHASE_N =
    {8'd80, 8'd80, 8'd80, 8'd100, 8'd80, 8'd100, 8'd80, 8'd80, 8'd120, 8'd40};

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [23:0]                   s_tdata = '0;  // opcode, pos_x, pos_y, colour_value
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [23:0]                   m_tdata;       // pixel_value, current_colour_out, status
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [pctf_pkg::DIM_BITS-1:0] cfg_data = '0;

  pixel_canvas_tool_with_flood_fill_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted canvas, pen and settings
  logic [pctf_pkg::PIX_BITS-1:0] canvas_img [pctf_pkg::STORE_DEPTH];
  logic [pctf_pkg::PIX_BITS-1:0] pen_colour = pctf_pkg::RESET_COLOUR;
  logic [pctf_pkg::DIM_BITS-1:0] canvas_w = 7'd64;
  logic [pctf_pkg::DIM_BITS-1:0] canvas_h = 7'd64;
  int                            region_stack[$];

  pctf_pkg::item_t   tool_words[$];
  pctf_pkg::result_t pending_results[$];
  pctf_pkg::result_t want_r, got_r;
  int      failures = 0;
  bit      idle_on = 1'b0;
  int      send_gap = 0;
  int      ready_gap = 0;
  bit      hold_req = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_cycles = 0;

  function automatic int eff_dim(logic [pctf_pkg::DIM_BITS-1:0] v);
    return (v > pctf_pkg::MAX_SIDE) ? pctf_pkg::MAX_SIDE : int'(v);
  endfunction

  // Recolor a matching in-range pixel and remember it for its neighbors
  function automatic void claim_pixel(int x, int y, int w, int h,
                                      logic [pctf_pkg::PIX_BITS-1:0] from);
    int a;
    if (x < 0 || y < 0 || x >= w || y >= h) return;
    a = y * pctf_pkg::MAX_SIDE + x;
    if (canvas_img[a] != from) return;
    canvas_img[a] = pen_colour;
    region_stack.push_front(a);
  endfunction

  function automatic void flood_region(int sx, int sy, int w, int h);
    logic [pctf_pkg::PIX_BITS-1:0] from;
    int a;
    from = canvas_img[sy * pctf_pkg::MAX_SIDE + sx];
    region_stack.delete();
    claim_pixel(sx, sy, w, h, from);
    while (region_stack.size() > 0) begin
      a = region_stack.pop_front();
      claim_pixel(a % pctf_pkg::MAX_SIDE + 1, a / pctf_pkg::MAX_SIDE, w, h, from);
      claim_pixel(a % pctf_pkg::MAX_SIDE - 1, a / pctf_pkg::MAX_SIDE, w, h, from);
      claim_pixel(a % pctf_pkg::MAX_SIDE, a / pctf_pkg::MAX_SIDE + 1, w, h, from);
      claim_pixel(a % pctf_pkg::MAX_SIDE, a / pctf_pkg::MAX_SIDE - 1, w, h, from);
    end
  endfunction

  // Apply one tool word to the predicted canvas and give its result
  function automatic pctf_pkg::result_t apply_tool(pctf_pkg::item_t it);
    pctf_pkg::result_t r;
    int w, h, a;
    w = eff_dim(canvas_w);
    h = eff_dim(canvas_h);
    r = '0;
    if (it.op == pctf_pkg::OP_SETCOL) pen_colour = it.colour;
    if (it.x >= w || it.y >= h) begin
      r.status = pctf_pkg::ST_OUTSIDE;
    end else begin
      a = it.y * pctf_pkg::MAX_SIDE + it.x;
      r.status = pctf_pkg::ST_APPLIED;
      case (it.op)
        pctf_pkg::OP_PENCIL: canvas_img[a] = pen_colour;
        pctf_pkg::OP_FILL: begin
          if (canvas_img[a] == pen_colour) r.status = pctf_pkg::ST_SKIPPED;
          else flood_region(it.x, it.y, w, h);
        end
        pctf_pkg::OP_PICK: pen_colour = canvas_img[a];
        pctf_pkg::OP_ERASE: canvas_img[a] = pctf_pkg::TRANSPARENT;
        default: ;
      endcase
      r.pix = canvas_img[a];
    end
    r.colour = pen_colour;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 92) return $urandom_range(2, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [2:0] random_op(bit allow_fill);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return pctf_pkg::OP_PENCIL;
    if (r < 45) return allow_fill ? pctf_pkg::OP_FILL : pctf_pkg::OP_READ;
    if (r < 55) return pctf_pkg::OP_PICK;
    if (r < 65) return pctf_pkg::OP_ERASE;
    if (r < 85) return pctf_pkg::OP_SETCOL;
    if (r < 93) return pctf_pkg::OP_READ;
    if (r < 97) return OP_SPARE_LO;
    return OP_SPARE_HI;
  endfunction

  // Few colors so regions form; coordinates mostly on the canvas
  function automatic pctf_pkg::item_t random_tool(bit allow_fill);
    pctf_pkg::item_t it;
    int w, h;
    w = eff_dim(canvas_w);
    h = eff_dim(canvas_h);
    it.op = random_op(allow_fill);
    if (w > 0 && h > 0 && $urandom_range(0, 99) < 85) begin
      it.x = 6'($urandom_range(0, w - 1));
      it.y = 6'($urandom_range(0, h - 1));
    end else begin
      it.x = 6'($urandom_range(0, 63));
      it.y = 6'($urandom_range(0, 63));
    end
    if ($urandom_range(0, 4) == 0) it.colour = 8'($urandom_range(0, 255));
    else it.colour = 8'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic void queue_tool(logic [2:0] op, int x, int y,
                                     logic [pctf_pkg::PIX_BITS-1:0] c);
    pctf_pkg::item_t it;
    it.op = op;
    it.x = 6'(x);
    it.y = 6'(y);
    it.colour = c;
    tool_words.insert(tool_words.size(), it);
  endfunction

  task automatic write_reg(logic idx, logic [pctf_pkg::DIM_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pctf_pkg::CFG_WIDTH) canvas_w = val;
    else canvas_h = val;
  endtask

  // Wait for every word to go in and every result to come out
  task automatic drain();
    while (tool_words.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        pending_results.insert(pending_results.size(),
                               apply_tool(pctf_pkg::item_t'(s_tdata[22:0])));
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (tool_words.size() != 0) begin
          s_tdata <= {1'b0, tool_words.pop_front()};
          s_tvalid <= 1'b1;
          send_gap <= (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cycles <= 300;
      hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Receiver ready, with random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_gap <= 0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      m_tready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      ready_gap <= pick_gap() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_r = pctf_pkg::result_t'(m_tdata[17:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, got %h", $time, m_tdata);
        failures++;
      end else begin
        want_r = pending_results.pop_front();
        if (got_r.pix !== want_r.pix) begin
          $display("%0t: pixel_value expected %0d got %0d", $time, want_r.pix, got_r.pix);
          failures++;
        end
        if (got_r.colour !== want_r.colour) begin
          $display("%0t: current_colour_out expected %0d got %0d", $time,
                   want_r.colour, got_r.colour);
          failures++;
        end
        if (got_r.status !== want_r.status) begin
          $display("%0t: status expected %0d got %0d", $time, want_r.status, got_r.status);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    int p;
    foreach (canvas_img[i]) canvas_img[i] = pctf_pkg::TRANSPARENT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Full 64x64 canvas at reset settings
    queue_tool(pctf_pkg::OP_READ, 0, 0, 8'hFF);
    queue_tool(pctf_pkg::OP_PENCIL, 63, 63, 8'h00);
    queue_tool(pctf_pkg::OP_SETCOL, 5, 5, 8'h00);
    queue_tool(pctf_pkg::OP_FILL, 5, 5, 8'hFF);        // same colors, skipped
    queue_tool(pctf_pkg::OP_SETCOL, 0, 0, 8'hFF);
    queue_tool(pctf_pkg::OP_FILL, 0, 0, 8'h00);        // whole canvas but one corner
    queue_tool(pctf_pkg::OP_PICK, 63, 63, 8'h00);
    queue_tool(pctf_pkg::OP_ERASE, 63, 63, 8'hFF);
    queue_tool(pctf_pkg::OP_READ, 62, 63, 8'h00);
    queue_tool(OP_SPARE_LO, 63, 63, 8'hFF);
    queue_tool(OP_SPARE_HI, 0, 63, 8'h00);
    queue_tool(pctf_pkg::OP_SETCOL, 63, 0, 8'hAA);
    queue_tool(pctf_pkg::OP_PENCIL, 1, 0, 8'h00);
    queue_tool(pctf_pkg::OP_PENCIL, 0, 1, 8'h00);
    queue_tool(pctf_pkg::OP_SETCOL, 42, 21, 8'h11);
    queue_tool(pctf_pkg::OP_FILL, 0, 0, 8'h00);        // walled in, one pixel
    queue_tool(pctf_pkg::OP_PICK, 1, 0, 8'h00);
    drain();

    for (p = 0; p < PHASES; p++) begin
      write_reg(pctf_pkg::CFG_WIDTH, PHASE_W[p*7 +: 7]);
      write_reg(pctf_pkg::CFG_HEIGHT, PHASE_H[p*7 +: 7]);
      @(negedge clk);
      idle_on = (p % 3 != 2);
      if (p == 0) begin
        // empty canvas: all tools land outside, set colour still loads
        queue_tool(pctf_pkg::OP_PENCIL, 0, 0, 8'h00);
        queue_tool(pctf_pkg::OP_FILL, 0, 0, 8'h00);
        queue_tool(pctf_pkg::OP_PICK, 0, 0, 8'h00);
        queue_tool(pctf_pkg::OP_ERASE, 63, 63, 8'h00);
        queue_tool(pctf_pkg::OP_SETCOL, 63, 63, 8'h3C);
        queue_tool(pctf_pkg::OP_READ, 0, 4, 8'h00);
      end else if (p == 1) begin
        // oversized registers act as 64
        queue_tool(pctf_pkg::OP_READ, 63, 63, 8'h00);
        queue_tool(pctf_pkg::OP_PENCIL, 63, 0, 8'h00);
      end
      repeat (PHASE_N[p*8 +: 8]) tool_words.insert(tool_words.size(), random_tool(p != 1));
      if (p == 2) hold_req = 1'b1;
      drain();
    end

    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("[pixel_canvas_tool_with_flood_fill_unit] OK");
    end else begin
      $display("[pixel_canvas_tool_with_flood_fill_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("[pixel_canvas_tool_with_flood_fill_unit] ERROR");
    $finish;
  end

endmodule

// ----- pixel_canvas_tool_with_flood_fill_unit.f -----
sv/pctf_pkg.sv
sv/pctf_ram.sv
sv/pctf_engine.sv
sv/pixel_canvas_tool_with_flood_fill_unit.sv
sim/tb_pixel_canvas_tool_with_flood_fill_unit.sv
